FILE: rtl/core/ttt_pkg.sv
// tracker tempo translator shared definitions: tempo base table, divide
// constants, slide and speed constants, tempo mode codes, opcodes and register map. no dependencies.
`default_nettype none

package ttt_pkg;

    // numerator of the tempo divide and its width
    localparam int unsigned DIV_BITS = 21;
    localparam int unsigned CNT_W    = $clog2(DIV_BITS);
    localparam logic [DIV_BITS-1:0] DIVIDEND = 21'd1197255;

    // quotient ceiling for the normalize loop
    localparam logic [31:0] Q_LIMIT = 32'h0000_ffff;

    // slide clamp ceiling, fixed speed, floor reset value
    localparam logic [9:0] FINE_CAP    = 10'd100;
    localparam logic [4:0] FIXED_SPEED = 5'd16;
    localparam logic [7:0] MIN_BPM_RST = 8'd20;

    // tempo mode codes
    localparam logic [3:0] MODE_FIXED  = 4'd0;
    localparam logic [3:0] MODE_SCALED = 4'd1;

    // opcodes
    localparam logic OP_COARSE = 1'b0;
    localparam logic OP_FINE   = 1'b1;

    // register map: byte address width and register index bit
    localparam int unsigned ADDR_W = 3;
    localparam logic REG_MIN_BPM = 1'b0;

    // base tempo for each coarse tempo code
    function automatic logic [8:0] tempo_base(input logic [3:0] code);
        logic [8:0] v;
        case (code)
            4'd0:    v = 9'd256;
            4'd1:    v = 9'd128;
            4'd2:    v = 9'd64;
            4'd3:    v = 9'd42;
            4'd4:    v = 9'd32;
            4'd5:    v = 9'd25;
            4'd6:    v = 9'd21;
            4'd7:    v = 9'd18;
            4'd8:    v = 9'd16;
            4'd9:    v = 9'd14;
            4'd10:   v = 9'd12;
            4'd11:   v = 9'd11;
            4'd12:   v = 9'd10;
            4'd13:   v = 9'd9;
            4'd14:   v = 9'd9;
            default: v = 9'd8;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tracker_tempo_translator.sv
// tracker tempo translator top level: command decode, serial divider,
// normalize loop and output register. depends on ttt_pkg.
`default_nettype none

// Takes one tempo command per transfer and returns one result per command.
// A command is taken only while the sequencer is idle; a finished result sits
// in the output register, so the next command can be taken while it waits.
// A command passes through the update and evaluate states; the fixed mode
// then goes straight to the finish state, while the scaled mode runs the
// restoring divider, one quotient bit a cycle over the 21-bit numerator
// through one shared subtract and compare unit, followed by one shift a
// cycle in the normalize loop, which ends with a normalize count n of 0 to 5
// for a positive tempo and 16 for a negative one. A command with an invalid
// mode or, in the scaled mode, a zero tempo returns the held speed and bpm
// with applied low. min_bpm is written over the APB port at byte address 0.
module tracker_tempo_translator (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ttt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    // command channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_opcode,
    input  wire logic [7:0]                i_param,
    // result channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic      [4:0]                o_speed,
    output logic      [12:0]               o_bpm,
    output logic                           o_applied
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_EVAL,
        S_DIV,
        S_NORM,
        S_FIN
    } t_state;

    t_state r_state;

    // state and configuration
    logic [7:0]  r_min_bpm;
    logic [3:0]  r_coarse;
    logic [9:0]  r_fine;
    logic [3:0]  r_mode;
    logic [4:0]  r_last_speed;
    logic [12:0] r_last_bpm;

    // captured command and work registers
    logic        r_op;
    logic [7:0]  r_param;
    logic        r_dir_up;
    logic        r_dir_dn;
    logic [9:0]  r_div;
    logic [9:0]  r_rem;
    logic        r_neg;
    logic [31:0] r_q;
    logic [31:0] r_t;
    logic [4:0]  r_n;
    logic [ttt_pkg::CNT_W-1:0] r_cnt;
    logic [4:0]  r_speed_c;
    logic        r_ok;

    // output register
    logic        r_out_valid;
    logic [4:0]  r_out_speed;
    logic [12:0] r_out_bpm;
    logic        r_out_applied;

    // apb write strobe
    logic w_cfg_wr;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // apb read data
    always_comb begin
        if (paddr[2] == ttt_pkg::REG_MIN_BPM) begin
            prdata = {24'd0, r_min_bpm};
        end else begin
            prdata = 32'd0;
        end
    end

    // command nibbles
    logic [3:0] w_hi;
    logic [3:0] w_lo;
    assign w_hi = r_param[7:4];
    assign w_lo = r_param[3:0];

    // saturating fine tempo slide
    logic signed [10:0] w_fine_ext;
    logic signed [10:0] w_slide;
    logic        [9:0]  w_fine_sat;
    always_comb begin
        w_fine_ext = $signed({r_fine[9], r_fine});
        if (w_hi != 4'd0) begin
            w_slide = w_fine_ext + $signed({7'd0, w_hi});
        end else begin
            w_slide = w_fine_ext - $signed({7'd0, w_lo});
        end
        if (w_slide > 11'sd511) begin
            w_fine_sat = 10'h1ff;
        end else if (w_slide < -11'sd512) begin
            w_fine_sat = 10'h200;
        end else begin
            w_fine_sat = w_slide[9:0];
        end
    end

    // base tempo, slide clamp and translated tempo
    logic        [8:0]  w_base;
    logic signed [10:0] w_sum;
    logic        [9:0]  w_fine_c;
    logic signed [10:0] w_tmp;
    logic        [10:0] w_tneg;
    logic signed [11:0] w_fixed;
    always_comb begin
        w_base = ttt_pkg::tempo_base(r_coarse);
        w_sum  = $signed({2'd0, w_base}) + $signed({r_fine[9], r_fine});
        if (r_dir_dn && (w_sum <= 11'sd0)) begin
            w_fine_c = 10'd0;
        end else if (r_dir_up && (w_sum >= 11'sd100)) begin
            w_fine_c = ttt_pkg::FINE_CAP;
        end else begin
            w_fine_c = r_fine;
        end
        w_tmp   = $signed({2'd0, w_base}) + $signed({w_fine_c[9], w_fine_c});
        w_tneg  = 11'd0 - w_tmp;
        w_fixed = $signed({3'd0, w_base}) + $signed({w_fine_c[9], w_fine_c, 1'b0});
    end

    // shared subtract and compare unit of the divider
    logic [10:0] w_try;
    logic [10:0] w_diff;
    logic        w_qbit;
    logic [31:0] w_q_next;
    always_comb begin
        w_try    = {r_rem, ttt_pkg::DIVIDEND[r_cnt]};
        w_diff   = w_try - {1'b0, r_div};
        w_qbit   = (w_try >= {1'b0, r_div});
        w_q_next = {r_q[30:0], w_qbit};
    end

    // speed from the normalize count, bpm floor
    logic [4:0]  w_speed_n;
    logic [31:0] w_bpm_f;
    always_comb begin
        w_speed_n = r_n + 5'd3 + ((r_n >= 5'd2) ? 5'd1 : 5'd0);
        if ($signed(r_t) < $signed({24'd0, r_min_bpm})) begin
            w_bpm_f = {24'd0, r_min_bpm};
        end else begin
            w_bpm_f = r_t;
        end
    end

    // output register load at the end of a command
    logic w_out_load;
    assign w_out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_speed     = r_out_speed;
    assign o_bpm       = r_out_bpm;
    assign o_applied   = r_out_applied;

    // sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min_bpm    <= ttt_pkg::MIN_BPM_RST;
            r_coarse     <= 4'd0;
            r_fine       <= 10'd0;
            r_mode       <= ttt_pkg::MODE_FIXED;
            r_last_speed <= 5'd0;
            r_last_bpm   <= 13'd0;
            r_out_valid  <= 1'b0;
            r_dir_up     <= 1'b0;
            r_dir_dn     <= 1'b0;
            r_ok         <= 1'b0;
        end else begin
            if (w_cfg_wr && (paddr[2] == ttt_pkg::REG_MIN_BPM)) begin
                r_min_bpm <= pwdata[7:0];
            end

            // a finished command fills the output register, a result transfer frees it
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_opcode;
                        r_param <= i_param;
                        r_state <= S_UPD;
                    end
                end

                // apply the command to the tempo state
                S_UPD: begin
                    r_dir_up <= (r_op == ttt_pkg::OP_FINE) && (w_hi != 4'd0);
                    r_dir_dn <= (r_op == ttt_pkg::OP_FINE) && (w_hi == 4'd0)
                                && (w_lo != 4'd0);
                    if (r_op == ttt_pkg::OP_COARSE) begin
                        if (w_hi != 4'd0) begin
                            r_mode <= w_hi - 4'd1;
                        end else begin
                            r_coarse <= w_lo;
                        end
                    end else begin
                        if ((w_hi != 4'd0) || (w_lo != 4'd0)) begin
                            r_fine <= w_fine_sat;
                        end else begin
                            r_fine <= 10'd0;
                        end
                    end
                    r_state <= S_EVAL;
                end

                // clamp, pick the mode, then finish or start the divide
                S_EVAL: begin
                    if (r_mode > ttt_pkg::MODE_SCALED) begin
                        r_ok    <= 1'b0;
                        r_state <= S_FIN;
                    end else begin
                        r_fine <= w_fine_c;
                        if (r_mode == ttt_pkg::MODE_FIXED) begin
                            r_t       <= {{18{w_fixed[11]}}, w_fixed, 2'b00};
                            r_speed_c <= ttt_pkg::FIXED_SPEED;
                            r_ok      <= 1'b1;
                            r_state   <= S_FIN;
                        end else if (w_tmp == 11'sd0) begin
                            r_ok    <= 1'b0;
                            r_state <= S_FIN;
                        end else begin
                            r_neg   <= w_tmp[10];
                            r_div   <= w_tmp[10] ? w_tneg[9:0] : w_tmp[9:0];
                            r_t     <= {{21{w_tmp[10]}}, w_tmp};
                            r_rem   <= 10'd0;
                            r_q     <= 32'd0;
                            r_n     <= 5'd0;
                            r_cnt   <= ttt_pkg::CNT_W'(ttt_pkg::DIV_BITS - 1);
                            r_state <= S_DIV;
                        end
                    end
                end

                // one quotient bit per cycle
                S_DIV: begin
                    if (w_qbit) begin
                        r_rem <= w_diff[9:0];
                    end else begin
                        r_rem <= w_try[9:0];
                    end
                    if (r_cnt == '0) begin
                        r_q     <= r_neg ? (32'd0 - w_q_next) : w_q_next;
                        r_state <= S_NORM;
                    end else begin
                        r_q   <= w_q_next;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end

                // halve the quotient and double the tempo until it fits
                S_NORM: begin
                    if (r_q > ttt_pkg::Q_LIMIT) begin
                        r_q <= {1'b0, r_q[31:1]};
                        r_t <= {r_t[30:0], 1'b0};
                        r_n <= r_n + 5'd1;
                    end else begin
                        r_speed_c <= w_speed_n;
                        r_ok      <= 1'b1;
                        r_state   <= S_FIN;
                    end
                end

                // load the output register once it is free
                S_FIN: begin
                    if (w_out_load) begin
                        r_out_applied <= r_ok;
                        if (r_ok) begin
                            r_last_speed <= r_speed_c;
                            r_last_bpm   <= w_bpm_f[12:0];
                            r_out_speed  <= r_speed_c;
                            r_out_bpm    <= w_bpm_f[12:0];
                        end else begin
                            r_out_speed <= r_last_speed;
                            r_out_bpm   <= r_last_bpm;
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
